// ===== rtl/qoth_pkg.sv =====
// shared types and constants for the queue occupancy time histogram
// no dependencies; used by qoth_ctrl, qoth_dp and the top level
package qoth_pkg;

	localparam int LEVELS_DEF     = 64;
	localparam int COUNT_BITS_DEF = 48;

	localparam int OP_W    = 3;
	localparam int OCC_W   = 6;
	localparam int IDX_W   = 6;
	localparam int TIME_W  = 48;
	localparam int FIELD_W = 48;
	localparam int ERR_W   = 2;

	localparam logic [OCC_W-1:0] CAP_RESET = 6'd50;

	// slave tdata: event_time, accepted, bin_index, pad
	localparam int IN_DATA_W  = 56;
	localparam int IN_ACC_BIT = 48;
	localparam int IN_IDX_LSB = 49;
	// master tdata: occupancy, seven 48-bit fields, event_error
	localparam int OUT_DATA_W = 344;

	typedef enum logic [OP_W-1:0] {
		OP_ARRIVAL   = 3'd0,
		OP_DEPARTURE = 3'd1,
		OP_START     = 3'd2,
		OP_READ      = 3'd3,
		OP_RECEPTION = 3'd4
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK        = 2'd0,
		ERR_DEP_ZERO  = 2'd1,
		ERR_FULL      = 2'd2,
		ERR_TIME_BACK = 2'd3
	} err_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic commit;
		logic clr_en;
	} qoth_cmd_t;

	typedef struct packed {
		logic out_free;
		logic start_ok;
	} qoth_status_t;

endpackage

// ===== rtl/qoth_ctrl.sv =====
// sequencer for the occupancy histogram: bin clearing, read, write-back
// depends on qoth_pkg
module qoth_ctrl #(
	parameter int LEVELS = qoth_pkg::LEVELS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  qoth_pkg::qoth_status_t    st,
	output qoth_pkg::qoth_cmd_t       cmd,
	output logic [$clog2(LEVELS)-1:0] clr_addr
);
	import qoth_pkg::*;

	localparam int AW = $clog2(LEVELS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(LEVELS - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_WRITE
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;

	assign s_tready   = (state_q == S_IDLE);
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.rd_en  = (state_q == S_READ);
	assign cmd.commit = (state_q == S_WRITE) && st.out_free;
	assign cmd.clr_en = (state_q == S_CLEAR);
	assign clr_addr   = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == LAST_ADDR) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (st.out_free) begin
						state_q <= st.start_ok ? S_CLEAR : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_hold_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && !st.out_free) |=> (state_q == S_WRITE))
		else $error("write-back left while output register was full");

	a_sweep_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && clr_q == LAST_ADDR) |=> (state_q == S_IDLE && clr_q == '0))
		else $error("clearing sweep did not finish in idle");

endmodule

// ===== rtl/qoth_dp.sv =====
// datapath for the occupancy histogram: bin memories, counters, result register
// depends on qoth_pkg; driven by qoth_ctrl commands
module qoth_dp #(
	parameter int LEVELS     = qoth_pkg::LEVELS_DEF,
	parameter int COUNT_BITS = qoth_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [qoth_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic [qoth_pkg::OP_W-1:0]         s_tuser,
	input  logic                              cfg_we,
	input  logic [qoth_pkg::OCC_W-1:0]        cfg_wdata,
	input  qoth_pkg::qoth_cmd_t               cmd,
	input  logic [$clog2(LEVELS)-1:0]         clr_addr,
	output qoth_pkg::qoth_status_t            st,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [qoth_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import qoth_pkg::*;

	localparam int AW  = $clog2(LEVELS);
	localparam int CW  = COUNT_BITS;
	localparam int SW  = (CW > TIME_W) ? CW : TIME_W;
	localparam int SW1 = SW + 1;
	localparam logic [CW-1:0] SAT_MAX = '1;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// captured beat
	logic [OP_W-1:0]   op_q;
	logic [TIME_W-1:0] now_q;
	logic              acc_q;
	logic [IDX_W-1:0]  idx_q;

	// architectural state
	logic [OCC_W-1:0]  cap_q;
	logic [OCC_W-1:0]  in_sys_q;
	logic              meas_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] start_q;
	logic [CW-1:0]     offered_q, dropped_q, departed_q, received_q;

	// read stage
	logic [TIME_W-1:0] delta_q;
	logic              back_q;
	logic [CW-1:0]     rd_time_q, rd_arr_q;

	logic [CW-1:0]     time_mem [LEVELS];
	logic [CW-1:0]     arr_mem  [LEVELS];

	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [AW-1:0]     slot, raddr, waddr;
	logic              timed, idx_ok;
	logic [TIME_W:0]   diff;
	logic [SW1-1:0]    tsum;
	logic [CW-1:0]     tsat;

	logic [OCC_W-1:0]  nxt_in_sys;
	logic              nxt_meas;
	logic [TIME_W-1:0] nxt_last, nxt_start;
	logic [CW-1:0]     nxt_off, nxt_drop, nxt_dep, nxt_rec;
	logic [CW-1:0]     bin_t, bin_a;
	err_t              err;
	logic              take, upd_time, upd_arr;
	logic              time_we, arr_we;
	logic [CW-1:0]     time_wdata, arr_wdata;

	assign slot   = (32'(in_sys_q) >= LEVELS) ? AW'(LEVELS - 1) : AW'(in_sys_q);
	assign raddr  = (op_q == OP_READ) ? AW'(idx_q) : slot;
	assign waddr  = cmd.clr_en ? clr_addr : slot;
	assign idx_ok = (32'(idx_q) < LEVELS);
	assign timed  = (op_q == OP_ARRIVAL) || (op_q == OP_DEPARTURE) || (op_q == OP_START);
	assign diff   = {1'b0, now_q} - {1'b0, last_q};

	assign tsum = SW1'(rd_time_q) + SW1'(delta_q);
	assign tsat = (tsum >= SW1'(SAT_MAX)) ? SAT_MAX : CW'(tsum);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tuser;
			now_q <= s_tdata[TIME_W-1:0];
			acc_q <= s_tdata[IN_ACC_BIT];
			idx_q <= s_tdata[IN_IDX_LSB +: IDX_W];
		end
		if (cmd.rd_en) begin
			delta_q <= diff[TIME_W-1:0];
			back_q  <= timed && diff[TIME_W];
		end
	end

	always_comb begin
		nxt_in_sys = in_sys_q;
		nxt_meas   = meas_q;
		nxt_last   = last_q;
		nxt_start  = start_q;
		nxt_off    = offered_q;
		nxt_drop   = dropped_q;
		nxt_dep    = departed_q;
		nxt_rec    = received_q;
		bin_t      = '0;
		bin_a      = '0;
		err        = ERR_OK;
		take       = 1'b0;
		upd_time   = 1'b0;
		upd_arr    = 1'b0;
		if (back_q) begin
			err = ERR_TIME_BACK;
		end else begin
			case (op_q)
				OP_ARRIVAL: begin
					nxt_last = now_q;
					take     = acc_q;
					if (acc_q && in_sys_q >= cap_q) begin
						take = 1'b0;
						err  = ERR_FULL;
					end
					if (meas_q) begin
						upd_time = 1'b1;
						upd_arr  = 1'b1;
						nxt_off  = sat_inc(offered_q);
						if (!take) begin
							nxt_drop = sat_inc(dropped_q);
						end
					end
					if (take) begin
						nxt_in_sys = in_sys_q + 1'b1;
					end
				end
				OP_DEPARTURE: begin
					nxt_last = now_q;
					upd_time = meas_q;
					if (in_sys_q == '0) begin
						err = ERR_DEP_ZERO;
					end else begin
						nxt_in_sys = in_sys_q - 1'b1;
						if (meas_q) begin
							nxt_dep = sat_inc(departed_q);
						end
					end
				end
				OP_START: begin
					nxt_last  = now_q;
					nxt_start = now_q;
					nxt_off   = '0;
					nxt_drop  = '0;
					nxt_dep   = '0;
					nxt_rec   = '0;
					nxt_meas  = 1'b1;
				end
				OP_READ: begin
					if (idx_ok) begin
						bin_t = rd_time_q;
						bin_a = rd_arr_q;
					end
				end
				OP_RECEPTION: begin
					if (meas_q) begin
						nxt_rec = sat_inc(received_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign time_we    = cmd.clr_en || (cmd.commit && upd_time);
	assign arr_we     = cmd.clr_en || (cmd.commit && upd_arr);
	assign time_wdata = cmd.clr_en ? '0 : tsat;
	assign arr_wdata  = cmd.clr_en ? '0 : sat_inc(rd_arr_q);

	always_ff @(posedge clk) begin
		if (time_we) begin
			time_mem[waddr] <= time_wdata;
		end
		if (cmd.rd_en) begin
			rd_time_q <= time_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (arr_we) begin
			arr_mem[waddr] <= arr_wdata;
		end
		if (cmd.rd_en) begin
			rd_arr_q <= arr_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CAP_RESET;
			in_sys_q   <= '0;
			meas_q     <= 1'b0;
			last_q     <= '0;
			start_q    <= '0;
			offered_q  <= '0;
			dropped_q  <= '0;
			departed_q <= '0;
			received_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				in_sys_q   <= nxt_in_sys;
				meas_q     <= nxt_meas;
				last_q     <= nxt_last;
				start_q    <= nxt_start;
				offered_q  <= nxt_off;
				dropped_q  <= nxt_drop;
				departed_q <= nxt_dep;
				received_q <= nxt_rec;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= {err, nxt_start, FIELD_W'(nxt_rec), FIELD_W'(nxt_dep),
				FIELD_W'(nxt_drop), FIELD_W'(nxt_off), FIELD_W'(bin_a),
				FIELD_W'(bin_t), nxt_in_sys};
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = m_tdata_q;
	assign st.out_free = !m_tvalid_q || m_tready;
	assign st.start_ok = (op_q == OP_START) && !back_q;

	a_drop_le_offer: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q <= offered_q)
		else $error("more drops than offered arrivals");

	a_idle_counters_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!meas_q |-> (offered_q == '0 && dropped_q == '0 && departed_q == '0
			&& received_q == '0))
		else $error("counter moved before measurement start");

	a_occ_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(in_sys_q))
		else $error("occupancy changed without a write-back");

endmodule

// ===== rtl/queue_occupancy_time_histogram.sv =====
// top level of the time-weighted queue occupancy histogram
// depends on qoth_pkg, qoth_ctrl and qoth_dp
//
// a beat is taken, its bin is read, and the result beat is registered at write-back,
//   which waits while the output register is still full; a new event is taken only
//   once the previous one's read-modify-write of the bin memories is done
// a start event without a time error sweeps all LEVELS bins clear before the next beat
// reset: asynchronous, active low; capacity returns to 50, occupancy, counters, window
//   state and output valid to zero, and a clearing pass over all LEVELS bins runs
//   before the first beat is taken (capacity writes are taken during it)
module queue_occupancy_time_histogram #(
	parameter int LEVELS     = qoth_pkg::LEVELS_DEF,
	parameter int COUNT_BITS = qoth_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// event input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [47:0] event_time, [48] accepted, [54:49] bin_index, [55] zero
	input  logic [qoth_pkg::IN_DATA_W-1:0]  s_tdata,
	// [2:0] operation
	input  logic [qoth_pkg::OP_W-1:0]       s_tuser,
	// result output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [5:0] occupancy, [53:6] time_in_bin, [101:54] arrivals_seen_in_bin,
	// [149:102] offered_total, [197:150] dropped_total, [245:198] departed_total,
	// [293:246] received_total, [341:294] window_start, [343:342] event_error
	output logic [qoth_pkg::OUT_DATA_W-1:0] m_tdata,
	// capacity register write
	input  logic                            cfg_we,
	input  logic [qoth_pkg::OCC_W-1:0]      cfg_wdata
);
	import qoth_pkg::*;

	// command and status between sequencer and datapath
	qoth_cmd_t                 cmd;
	qoth_status_t              st;
	logic [$clog2(LEVELS)-1:0] clr_addr;

	// sequencer: sweeps the bins after reset and after each start without a time error,
	// then steps each beat through read and write-back
	qoth_ctrl #(
		.LEVELS (LEVELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	// datapath: bin memories, saturating counters, occupancy tracking
	// and the output register that holds a finished beat
	qoth_dp #(
		.LEVELS     (LEVELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.clr_addr  (clr_addr),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
